@@ src/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Table geometry, node and request layouts, operation and status codes.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Table geometry; BUCKETS is a power of two of at least two
    localparam int BUCKETS = 16;
    localparam int NODES   = 64;

    localparam int KEY_W  = 31;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = $clog2(NODES);
    // A link also holds NODES, which marks the end of a chain
    localparam int LINK_W = $clog2(NODES + 1);

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NODES);

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_SEARCH = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_LINK,
        S_DONE
    } t_state;

    // One pool node: its key and the link to the next node of the chain
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] next;
    } t_node;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        t_node             wr_data;
    } t_node_req;

    typedef struct packed {
        logic              rd_en;
        logic [BKT_W-1:0]  rd_addr;
        logic              wr_en;
        logic [BKT_W-1:0]  wr_addr;
        logic [NODE_W-1:0] wr_ptr;
    } t_head_req;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] ptr;
    } t_head_rd;

endpackage

@@ src/cht_req_if.sv @@
// ----------------------------------------------------------------------------
// cht_req_if: request channel of the chained hash table
// Carries one operation item: insert or search, and the key.
// ----------------------------------------------------------------------------
interface cht_req_if
    import cht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

@@ src/cht_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cht_rsp_if: response channel of the chained hash table
// Carries one result item: status code and the matched key.
// ----------------------------------------------------------------------------
interface cht_rsp_if
    import cht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [KEY_W-1:0] found_key;

    modport source (output valid, output status, output found_key, input ready);
    modport sink   (input valid, input status, input found_key, output ready);
endinterface

@@ src/cht_head_mem.sv @@
// ----------------------------------------------------------------------------
// cht_head_mem: bucket head table
// Head pointer memory with registered read, plus per-bucket valid flops.
// ----------------------------------------------------------------------------
module cht_head_mem
    import cht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_head_req i_req,
    output t_head_rd  o_rd
);

    logic [NODE_W-1:0]  r_ptr_mem [BUCKETS];
    logic [BUCKETS-1:0] r_valid;
    t_head_rd           r_rd;

    // Write head pointers; no reset, a bucket is read only once valid
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_ptr_mem[i_req.wr_addr] <= i_req.wr_ptr;
        end
    end

    // Mark buckets occupied; reset empties every bucket
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Register the read of pointer and valid bit
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd.ptr   <= r_ptr_mem[i_req.rd_addr];
            r_rd.valid <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

@@ src/cht_node_mem.sv @@
// ----------------------------------------------------------------------------
// cht_node_mem: node pool memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_node_mem
    import cht_pkg::*;
(
    input  logic      i_clk,
    input  t_node_req i_req,
    output t_node     o_rd
);

    t_node r_mem [NODES];
    t_node r_rd;

    // Write one node
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Register the read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

@@ src/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl: operation sequencer of the chained hash table
// Reads the bucket head, walks the sorted chain one node per cycle,
// links new nodes from the pool and registers the result item.
// ----------------------------------------------------------------------------
module cht_ctrl
    import cht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cht_req_if.sink    i_req,
    cht_rsp_if.source  o_rsp,
    output t_head_req  o_head_req,
    input  t_head_rd   i_head_rd,
    output t_node_req  o_node_req,
    input  t_node      i_node_rd
);

    t_state            r_state,      n_state;
    t_mode             r_mode,       n_mode;
    logic [KEY_W-1:0]  r_key,        n_key;
    logic [LINK_W-1:0] r_cur,        n_cur;
    logic              r_first,      n_first;
    logic [NODE_W-1:0] r_prev,       n_prev;
    logic [KEY_W-1:0]  r_prev_key,   n_prev_key;
    logic [LINK_W-1:0] r_used,       n_used;
    t_status           r_res_status, n_res_status;
    logic [KEY_W-1:0]  r_res_key,    n_res_key;
    logic              r_out_valid,  n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [KEY_W-1:0]  r_out_key,    n_out_key;

    logic              pool_full;
    logic [NODE_W-1:0] new_node;
    logic [NODE_W-1:0] last_node;
    logic [BKT_W-1:0]  bucket;

    assign pool_full = (r_used == LINK_END);
    assign new_node  = r_used[NODE_W-1:0];
    assign last_node = NODE_W'(r_used - 1'b1);
    // Bucket count is a power of two: the remainder is the low key bits
    assign bucket    = r_key[BKT_W-1:0];

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_cur        <= n_cur;
        r_first      <= n_first;
        r_prev       <= n_prev;
        r_prev_key   <= n_prev_key;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
    end

    // Next state, memory requests and result
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_cur        = r_cur;
        n_first      = r_first;
        n_prev       = r_prev;
        n_prev_key   = r_prev_key;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_key    = r_res_key;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        o_head_req   = '0;
        o_node_req   = '0;
        i_req.ready  = (r_state == S_IDLE);

        // Drop the output item once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Take an item and fetch its bucket head
                if (i_req.valid) begin
                    n_mode             = t_mode'(i_req.mode);
                    n_key              = i_req.key;
                    o_head_req.rd_en   = 1'b1;
                    o_head_req.rd_addr = i_req.key[BKT_W-1:0];
                    n_state            = S_HEAD;
                end
            end

            S_HEAD: begin
                n_res_key = '0;
                if (r_mode == MODE_INSERT && pool_full) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else if (!i_head_rd.valid) begin
                    if (r_mode == MODE_INSERT) begin
                        // Empty bucket: the new node becomes the whole chain
                        o_node_req.wr_en   = 1'b1;
                        o_node_req.wr_addr = new_node;
                        o_node_req.wr_data = '{key: r_key, next: LINK_END};
                        o_head_req.wr_en   = 1'b1;
                        o_head_req.wr_addr = bucket;
                        o_head_req.wr_ptr  = new_node;
                        n_used             = r_used + 1'b1;
                        n_res_status       = ST_INSERTED;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    // Fetch the chain head node
                    o_node_req.rd_en   = 1'b1;
                    o_node_req.rd_addr = i_head_rd.ptr;
                    n_cur              = LINK_W'(i_head_rd.ptr);
                    n_first            = 1'b1;
                    n_state            = S_WALK;
                end
            end

            S_WALK: begin
                n_res_key = '0;
                if (r_mode == MODE_SEARCH) begin
                    if (i_node_rd.key == r_key) begin
                        n_res_status = ST_FOUND;
                        n_res_key    = r_key;
                        n_state      = S_DONE;
                    end else if (i_node_rd.next == LINK_END) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else begin
                        o_node_req.rd_en   = 1'b1;
                        o_node_req.rd_addr = i_node_rd.next[NODE_W-1:0];
                        n_cur              = i_node_rd.next;
                    end
                end else if (i_node_rd.key >= r_key) begin
                    // New node goes before the current node
                    o_node_req.wr_en   = 1'b1;
                    o_node_req.wr_addr = new_node;
                    o_node_req.wr_data = '{key: r_key, next: r_cur};
                    n_used             = r_used + 1'b1;
                    n_res_status       = ST_INSERTED;
                    if (r_first) begin
                        o_head_req.wr_en   = 1'b1;
                        o_head_req.wr_addr = bucket;
                        o_head_req.wr_ptr  = new_node;
                        n_state            = S_DONE;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    // Current node is smaller: it becomes the predecessor
                    n_prev     = r_cur[NODE_W-1:0];
                    n_prev_key = i_node_rd.key;
                    n_first    = 1'b0;
                    if (i_node_rd.next == LINK_END) begin
                        // Append at the tail
                        o_node_req.wr_en   = 1'b1;
                        o_node_req.wr_addr = new_node;
                        o_node_req.wr_data = '{key: r_key, next: LINK_END};
                        n_used             = r_used + 1'b1;
                        n_res_status       = ST_INSERTED;
                        n_state            = S_LINK;
                    end else begin
                        o_node_req.rd_en   = 1'b1;
                        o_node_req.rd_addr = i_node_rd.next[NODE_W-1:0];
                        n_cur              = i_node_rd.next;
                    end
                end
            end

            S_LINK: begin
                // Point the predecessor at the new node
                o_node_req.wr_en   = 1'b1;
                o_node_req.wr_addr = r_prev;
                o_node_req.wr_data = '{key: r_prev_key, next: LINK_W'(last_node)};
                n_state            = S_DONE;
            end

            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_key    = r_res_key;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.found_key = r_out_key;

    // The pool count never passes the pool size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LINK_END)
        else $error("node pool count beyond pool size");

    // The pool count grows by at most one node per cycle
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1))
        else $error("node pool count jumped");

    // A predecessor relink, mid-chain or at the tail, only follows a strictly smaller predecessor
    a_link_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_prev_key < r_key))
        else $error("chain order broken at link");

    // Table full is reported only with the pool exhausted
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_FULL) |-> pool_full)
        else $error("table full reported with free nodes");

endmodule

@@ src/chained_hash_table_sorted.sv @@
// Sequence: accept, head read, a walk of one chain node per cycle when the bucket
//   is not empty, a relink of the predecessor when one is needed, and the output load.
// One item at a time; the next item is taken the cycle after the result is
//   loaded, and loading waits while the output register still holds a reply.
// Reset (synchronous, active low): all buckets empty, pool count zero; no
//   clearing pass, an item may be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// chained_hash_table_sorted: hash table with sorted separate chaining
// Insert and search over a fixed node pool held in on-chip memories.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted
    import cht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);

    t_head_req head_req;
    t_head_rd  head_rd;
    t_node_req node_req;
    t_node     node_rd;

    // Sequencer
    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_head_req (head_req),
        .i_head_rd  (head_rd),
        .o_node_req (node_req),
        .i_node_rd  (node_rd)
    );

    // Bucket heads
    cht_head_mem u_head_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (head_req),
        .o_rd    (head_rd)
    );

    // Node pool
    cht_node_mem u_node_mem (
        .i_clk (i_clk),
        .i_req (node_req),
        .o_rd  (node_rd)
    );

endmodule

@@ tb/chained_hash_table_sorted_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_checker: reply checker of the chained hash table
// Keeps its own copy of the bucket heads and the node pool. For every request
// item it works out the reply, then compares replies in order, field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted_checker
    import cht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cht_req_if   i_req_mon,
    cht_rsp_if   i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_inserted,
    output int   o_full,
    output int   o_found,
    output int   o_missed
);

    typedef struct {
        t_mode            mode;
        logic [KEY_W-1:0] key;
        t_status          status;
        logic [KEY_W-1:0] found_key;
    } t_reply;

    // Shadow copy of the table
    bit                bucket_used [BUCKETS];
    logic [NODE_W-1:0] bucket_head [BUCKETS];
    logic [KEY_W-1:0]  pool_key    [NODES];
    logic [LINK_W-1:0] pool_link   [NODES];
    int                pool_fill;

    t_reply replies_due[$];

    // Take the next pool node and link it into its sorted chain
    function automatic t_status insert_key(input logic [KEY_W-1:0] key);
        int bkt;
        int n;
        int prev;
        int cur;
        bkt = key % BUCKETS;
        if (pool_fill >= NODES)
            return ST_FULL;
        n = pool_fill;
        pool_fill++;
        pool_key[n]  = key;
        pool_link[n] = LINK_END;
        if (!bucket_used[bkt]) begin
            bucket_used[bkt] = 1'b1;
            bucket_head[bkt] = NODE_W'(n);
        end else if (pool_key[bucket_head[bkt]] >= key) begin
            // Equal or smaller than the head: the new node becomes the head
            pool_link[n]     = LINK_W'(bucket_head[bkt]);
            bucket_head[bkt] = NODE_W'(n);
        end else begin
            prev = bucket_head[bkt];
            cur  = pool_link[prev];
            while (cur != NODES && pool_key[cur] < key) begin
                prev = cur;
                cur  = pool_link[cur];
            end
            pool_link[n]    = LINK_W'(cur);
            pool_link[prev] = LINK_W'(n);
        end
        return ST_INSERTED;
    endfunction

    // Walk the chain of the key's bucket
    function automatic bit holds_key(input logic [KEY_W-1:0] key);
        int bkt;
        int cur;
        bkt = key % BUCKETS;
        if (!bucket_used[bkt])
            return 1'b0;
        cur = bucket_head[bkt];
        while (cur != NODES) begin
            if (pool_key[cur] == key)
                return 1'b1;
            cur = pool_link[cur];
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_reply due;
        if (!i_rst_n) begin
            foreach (bucket_used[b])
                bucket_used[b] = 1'b0;
            pool_fill = 0;
            replies_due.delete();
            o_pending = 0;
        end else begin
            // Compare an accepted reply with the oldest prediction
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (replies_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] reply with none due: status=%0d found_key=%0h",
                                 $realtime, i_rsp_mon.status, i_rsp_mon.found_key);
                end else begin
                    due = replies_due.pop_front();
                    if (i_rsp_mon.status !== due.status ||
                        i_rsp_mon.found_key !== due.found_key) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $write("[%0t] %s key=%0h: expected status=%s found_key=%0h,",
                                   $realtime, due.mode.name(), due.key, due.status.name(),
                                   due.found_key);
                            $display(" got status=%0d found_key=%0h",
                                     i_rsp_mon.status, i_rsp_mon.found_key);
                        end
                    end
                end
            end

            // Predict the reply of an accepted request
            if (i_req_mon.valid && i_req_mon.ready) begin
                due.mode      = t_mode'(i_req_mon.mode);
                due.key       = i_req_mon.key;
                due.found_key = '0;
                if (due.mode == MODE_INSERT) begin
                    due.status = insert_key(due.key);
                    if (due.status == ST_FULL)
                        o_full++;
                    else
                        o_inserted++;
                end else if (holds_key(due.key)) begin
                    due.status    = ST_FOUND;
                    due.found_key = due.key;
                    o_found++;
                end else begin
                    due.status = ST_NOT_FOUND;
                    o_missed++;
                end
                replies_due.push_back(due);
            end
            o_pending = replies_due.size();
        end
    end

endmodule

@@ tb/chained_hash_table_sorted_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_tb: testbench of the chained hash table
// Sends directed inserts and searches over chain heads, middles and tails,
// then random traffic that fills the pool and keeps searching, with random
// stalls on both channels. The checker beside the block judges every reply.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted_tb;
    import cht_pkg::*;

    localparam int RANDOM_ITEMS = 1180;
    localparam int STALL_LIMIT  = 2000;
    // Drain margin covers a walk over the whole pool plus the per-item overhead
    localparam int DRAIN_CYCLES = NODES + 16;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady;
    int   stall_cycles = 0;
    int   inserts_sent = 0;
    int   fail_count;
    int   pending;
    int   inserted;
    int   full_replies;
    int   found;
    int   missed;

    logic [KEY_W-1:0] stored_keys[$];

    cht_req_if req_ch();
    cht_rsp_if rsp_ch();

    chained_hash_table_sorted DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    chained_hash_table_sorted_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_inserted   (inserted),
        .o_full       (full_replies),
        .o_found      (found),
        .o_missed     (missed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the reply side at random, except in the steady stretch
    always @(negedge i_clk) begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 23);
    end

    // End the run if no item moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved in %0d cycles, %0d replies still due",
                     stall_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Hold one request item until accepted; idle before it at random
    task automatic send_op(input t_mode mode, input logic [KEY_W-1:0] key);
        while (!steady && $urandom_range(0, 99) < 23) begin
            req_ch.valid <= 1'b0;
            req_ch.mode  <= 1'($urandom_range(0, 1));
            req_ch.key   <= KEY_W'($urandom);
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= key;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic put_key(input logic [KEY_W-1:0] key);
        send_op(MODE_INSERT, key);
        if (inserts_sent < NODES)
            stored_keys.push_back(key);
        inserts_sent++;
    endtask

    task automatic probe_key(input logic [KEY_W-1:0] key);
        send_op(MODE_SEARCH, key);
    endtask

    // Mix crowded small keys, full-range keys, duplicates and bucket mates
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned      roll;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] offset;
        roll = $urandom_range(0, 99);
        if (roll < 35 || stored_keys.size() == 0)
            return KEY_W'($urandom_range(0, 191));
        if (roll < 60)
            return KEY_W'($urandom);
        base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (roll < 75)
            return base;
        offset = KEY_W'(BUCKETS * $urandom_range(1, 3));
        return $urandom_range(0, 1) ? base + offset : base - offset;
    endfunction

    initial begin
        int unsigned roll;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_INSERT;
        req_ch.key   = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, head, middle and tail placement, duplicates
        probe_key(KEY_W'(0));
        put_key(KEY_W'(32));
        put_key(KEY_W'(16));
        put_key(KEY_W'(16));
        put_key(KEY_W'(48));
        put_key(KEY_W'(32));
        put_key(KEY_W'(0));
        put_key({KEY_W{1'b1}});
        put_key({KEY_W{1'b1}});
        put_key(KEY_W'(1));
        put_key(KEY_W'(31'h5555_5555));
        put_key(KEY_W'(31'h2AAA_AAAA));
        probe_key(KEY_W'(0));
        probe_key(KEY_W'(16));
        probe_key(KEY_W'(32));
        probe_key(KEY_W'(48));
        probe_key(KEY_W'(64));
        probe_key(KEY_W'(24));
        probe_key(KEY_W'(33));
        probe_key({KEY_W{1'b1}});
        probe_key(KEY_W'(31'h7FFF_FFEF));
        probe_key(KEY_W'(31'h7FFF_FFF0));
        probe_key(KEY_W'(31'h5555_5555));

        // Random: fill the pool, then mostly searches with late full inserts
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady <= (i >= 400 && i < 650);
            roll = $urandom_range(0, 99);
            if (roll < ((inserts_sent < NODES + 8) ? 60 : 12))
                put_key(pick_key());
            else if (roll[0] && stored_keys.size() > 0)
                probe_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else
                probe_key(pick_key());
        end
        req_ch.valid <= 1'b0;

        // Drain, then allow time for any stray reply
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d items: %0d inserts, %0d table-full replies, %0d hits, %0d misses",
                 inserted + full_replies + found + missed, inserted, full_replies, found, missed);
        $display("Pool of %0d nodes ran out; %0d replies failed the check",
                 NODES, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
